FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An expression that must never be true at a rising edge while reset is low.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/mbf_pkg.sv
// Package of the multipass biquad filter: widths, register map, reset values and shared types.
package mbf_pkg;

   localparam int BLOCK_DEPTH_DEF    = 64;
   localparam int COEF_FRAC_BITS_DEF = 30;

   localparam int SAMPLE_W   = 32;
   localparam int RESULT_W   = 48;
   localparam int COEF_W     = 32;
   localparam int ACC_W      = 64;
   localparam int PASS_W     = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_COEF_FF0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_FF1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_FF2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_FB1 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_FB2 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PASSES   = 3'd5;

   localparam logic signed [COEF_W-1:0] COEF_FF0_RST = 32'sd16931232;
   localparam logic signed [COEF_W-1:0] COEF_FF1_RST = 32'sd33862464;
   localparam logic signed [COEF_W-1:0] COEF_FF2_RST = 32'sd16931232;
   localparam logic signed [COEF_W-1:0] COEF_FB1_RST = -32'sd1770756212;
   localparam logic signed [COEF_W-1:0] COEF_FB2_RST = 32'sd764739313;
   localparam logic [PASS_W-1:0]        PASSES_RST   = 8'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } req_word_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] filtered;
      logic                       result_end;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_ff0;
      logic signed [COEF_W-1:0] coef_ff1;
      logic signed [COEF_W-1:0] coef_ff2;
      logic signed [COEF_W-1:0] coef_fb1;
      logic signed [COEF_W-1:0] coef_fb2;
      logic [PASS_W-1:0]        passes;
   } cfg_type;

   typedef struct packed {
      logic load_wr;
      logic clr_state;
      logic smp_rd;
      logic ld_x;
      logic st_y;
      logic st_yq;
      logic st_mul;
      logic st_psum;
      logic st_sub;
      logic st_upd;
      logic wb_smp;
      logic wb_res;
      logic res_rd;
   } dp_cmd_type;

endpackage

FILE: hw/rtl/mbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mbf_csr.sv
// Configuration register file of the multipass biquad filter on an APB-style port.
module mbf_csr import mbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_COEF_FF0: cfg_in.coef_ff0 = pwdata;
            REG_COEF_FF1: cfg_in.coef_ff1 = pwdata;
            REG_COEF_FF2: cfg_in.coef_ff2 = pwdata;
            REG_COEF_FB1: cfg_in.coef_fb1 = pwdata;
            REG_COEF_FB2: cfg_in.coef_fb2 = pwdata;
            REG_PASSES:   cfg_in.passes   = pwdata[PASS_W-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_ff0 <= COEF_FF0_RST;
         cfg_ff.coef_ff1 <= COEF_FF1_RST;
         cfg_ff.coef_ff2 <= COEF_FF2_RST;
         cfg_ff.coef_fb1 <= COEF_FB1_RST;
         cfg_ff.coef_fb2 <= COEF_FB2_RST;
         cfg_ff.passes   <= PASSES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COEF_FF0: prdata = cfg_ff.coef_ff0;
         REG_COEF_FF1: prdata = cfg_ff.coef_ff1;
         REG_COEF_FF2: prdata = cfg_ff.coef_ff2;
         REG_COEF_FB1: prdata = cfg_ff.coef_fb1;
         REG_COEF_FB2: prdata = cfg_ff.coef_fb2;
         REG_PASSES:   prdata = CSR_DATA_W'(cfg_ff.passes);
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/mbf_ctrl.sv
// Controller of the multipass biquad filter: loading, pass and sample sequencing, result output.
module mbf_ctrl import mbf_pkg::*; #(
   parameter int BLOCK_DEPTH = BLOCK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_block_end,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_end,
   input  logic [PASS_W-1:0]              passes,
   output dp_cmd_type                     cmd,
   output logic [$clog2(BLOCK_DEPTH)-1:0] wr_addr,
   output logic [$clog2(BLOCK_DEPTH)-1:0] rd_addr
);

   localparam int AW = $clog2(BLOCK_DEPTH);
   localparam int CW = $clog2(BLOCK_DEPTH + 1);

   localparam logic [3:0] ST_LOAD      = 4'd0;
   localparam logic [3:0] ST_PRE_RD    = 4'd1;
   localparam logic [3:0] ST_PRE_MUL   = 4'd2;
   localparam logic [3:0] ST_Y         = 4'd3;
   localparam logic [3:0] ST_YQ        = 4'd4;
   localparam logic [3:0] ST_MUL       = 4'd5;
   localparam logic [3:0] ST_PSUM      = 4'd6;
   localparam logic [3:0] ST_SUB       = 4'd7;
   localparam logic [3:0] ST_UPD       = 4'd8;
   localparam logic [3:0] ST_EMIT_RD   = 4'd9;
   localparam logic [3:0] ST_EMIT_SEND = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [PASS_W-1:0] final_pass;
   logic              last_idx;
   logic              last_pass;

   assign final_pass = (passes == '0) ? '0 : passes - PASS_W'(1);
   assign last_pass  = (pass_ff == final_pass);
   assign last_idx   = (idx_ff == AW'(fill_ff - CW'(1)));

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load_wr   = 1'b1;
               cmd.clr_state = (fill_ff == '0);
               fill_in       = fill_ff + CW'(1);
               if (req_block_end || fill_ff == CW'(BLOCK_DEPTH - 1)) begin
                  idx_in   = '0;
                  pass_in  = '0;
                  state_in = ST_PRE_RD;
               end
            end
         end
         ST_PRE_RD: begin
            cmd.smp_rd = 1'b1;
            state_in   = ST_PRE_MUL;
         end
         ST_PRE_MUL: begin
            cmd.ld_x = 1'b1;
            state_in = ST_Y;
         end
         ST_Y: begin
            cmd.st_y = 1'b1;
            state_in = ST_YQ;
         end
         ST_YQ: begin
            cmd.st_yq = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.st_mul = 1'b1;
            state_in   = ST_PSUM;
         end
         ST_PSUM: begin
            cmd.st_psum = 1'b1;
            state_in    = ST_SUB;
         end
         ST_SUB: begin
            cmd.st_sub = 1'b1;
            cmd.wb_res = last_pass;
            cmd.wb_smp = !last_pass;
            cmd.smp_rd = !last_idx;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            cmd.st_upd = 1'b1;
            cmd.ld_x   = !last_idx;
            if (!last_idx) begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_Y;
            end else if (last_pass) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = '0;
               pass_in  = pass_ff + PASS_W'(1);
               state_in = ST_PRE_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.res_rd = 1'b1;
            state_in   = ST_EMIT_SEND;
         end
         ST_EMIT_SEND: begin
            if (rsp_ready) begin
               if (last_idx) begin
                  fill_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  cmd.res_rd = 1'b1;
                  idx_in     = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         idx_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         pass_ff  <= pass_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT_SEND);
   assign rsp_end   = last_idx;
   assign wr_addr   = (state_ff == ST_LOAD) ? fill_ff[AW-1:0] : idx_ff;
   assign rd_addr   = (state_ff == ST_PRE_RD || state_ff == ST_EMIT_RD) ? '0
                                                                          : idx_ff + AW'(1);

endmodule

FILE: hw/rtl/mbf_dp.sv
// Datapath of the multipass biquad filter: block stores, multipliers and saturating arithmetic.
module mbf_dp import mbf_pkg::*; #(
   parameter int BLOCK_DEPTH    = BLOCK_DEPTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   input  cfg_type                        cfg,
   input  logic [$clog2(BLOCK_DEPTH)-1:0] wr_addr,
   input  logic [$clog2(BLOCK_DEPTH)-1:0] rd_addr,
   input  logic [SAMPLE_W-1:0]            req_sample,
   output logic [RESULT_W-1:0]            rsp_filtered
);

   localparam int RND_SH = COEF_FRAC_BITS - 16;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'((64'd1 << RND_SH) >> 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
   localparam logic signed [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_sub = s[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_sub = s[ACC_W-1:0];
      end
   endfunction

   logic signed [COEF_W-1:0]   ff0, ff1, ff2, fb1, fb2;
   logic [SAMPLE_W-1:0]        smp_rd_data;
   logic [SAMPLE_W-1:0]        smp_wr_data;
   logic signed [SAMPLE_W-1:0] x_val;

   logic signed [ACC_W-1:0]    ffx0_ff, ffx1_ff, ffx2_ff;
   logic signed [ACC_W-1:0]    ffx0_in, ffx1_in, ffx2_in;
   logic signed [ACC_W-1:0]    y_ff, y_in;
   logic signed [RESULT_W-1:0] yq_ff, yq_in;
   logic signed [SAMPLE_W-1:0] xi_ff, xi_in;
   logic signed [ACC_W-1:0]    mhi1_ff, mhi2_ff, mhi1_in, mhi2_in;
   logic signed [48:0]         mlo1_ff, mlo2_ff, mlo1_in, mlo2_in;
   logic signed [ACC_W-1:0]    p1_ff, p2_ff, p1_in, p2_in;
   logic signed [ACC_W-1:0]    t1_ff, t1_in;
   logic signed [ACC_W-1:0]    s2n_ff, s2n_in;
   logic signed [ACC_W-1:0]    s1_ff, s1_in;
   logic signed [ACC_W-1:0]    s2_ff;

   logic signed [ACC_W-1:0]    y_rnd;
   logic signed [ACC_W-1:0]    y_sh;
   logic signed [ACC_W-1:0]    y_fl;
   logic signed [ACC_W-1:0]    y_int;
   logic                       y_adj;
   logic signed [31:0]         yq_hi;
   logic signed [16:0]         yq_lo;

   assign ff0 = cfg.coef_ff0;
   assign ff1 = cfg.coef_ff1;
   assign ff2 = cfg.coef_ff2;
   assign fb1 = cfg.coef_fb1;
   assign fb2 = cfg.coef_fb2;

   assign smp_wr_data = cmd.load_wr ? req_sample : xi_ff;

   mbf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BLOCK_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (cmd.load_wr || cmd.wb_smp),
      .wr_addr (wr_addr),
      .wr_data (smp_wr_data),
      .rd_en   (cmd.smp_rd),
      .rd_addr (rd_addr),
      .rd_data (smp_rd_data)
   );

   mbf_ram #(
      .WIDTH (RESULT_W),
      .DEPTH (BLOCK_DEPTH)
   ) u_result_ram (
      .clock   (clock),
      .wr_en   (cmd.wb_res),
      .wr_addr (wr_addr),
      .wr_data (yq_ff),
      .rd_en   (cmd.res_rd),
      .rd_addr (rd_addr),
      .rd_data (rsp_filtered)
   );

   assign x_val   = smp_rd_data;
   assign ffx0_in = ff0 * x_val;
   assign ffx1_in = ff1 * x_val;
   assign ffx2_in = ff2 * x_val;

   assign y_in = sat_add(ffx0_ff, s1_ff);

   // Round half up to 16 fraction bits, then saturate to the result width.
   assign y_rnd = sat_add(y_ff, RND_HALF);
   assign y_sh  = y_rnd >>> RND_SH;
   always_comb begin
      if ((&y_sh[ACC_W-1:RESULT_W-1]) || !(|y_sh[ACC_W-1:RESULT_W-1])) begin
         yq_in = y_sh[RESULT_W-1:0];
      end else begin
         yq_in = y_sh[ACC_W-1] ? RES_MIN : RES_MAX;
      end
   end

   // Truncate toward zero to an integer for the next pass, then saturate.
   assign y_fl  = y_ff >>> COEF_FRAC_BITS;
   assign y_adj = y_ff[ACC_W-1] && (|y_ff[COEF_FRAC_BITS-1:0]);
   assign y_int = y_fl + ACC_W'(y_adj);
   always_comb begin
      if ((&y_int[ACC_W-1:SAMPLE_W-1]) || !(|y_int[ACC_W-1:SAMPLE_W-1])) begin
         xi_in = y_int[SAMPLE_W-1:0];
      end else begin
         xi_in = y_int[ACC_W-1] ? SMP_MIN : SMP_MAX;
      end
   end

   // The feedback product is split into an upper and a lower part of the rounded output.
   assign yq_hi   = yq_ff[RESULT_W-1:16];
   assign yq_lo   = {1'b0, yq_ff[15:0]};
   assign mhi1_in = fb1 * yq_hi;
   assign mhi2_in = fb2 * yq_hi;
   assign mlo1_in = fb1 * yq_lo;
   assign mlo2_in = fb2 * yq_lo;

   assign p1_in = mhi1_ff + {{31{mlo1_ff[48]}}, mlo1_ff[48:16]};
   assign p2_in = mhi2_ff + {{31{mlo2_ff[48]}}, mlo2_ff[48:16]};

   assign t1_in  = sat_sub(ffx1_ff, p1_ff);
   assign s2n_in = sat_sub(ffx2_ff, p2_ff);
   assign s1_in  = sat_add(t1_ff, s2_ff);

   always_ff @(posedge clock) begin
      if (cmd.ld_x) begin
         ffx0_ff <= ffx0_in;
         ffx1_ff <= ffx1_in;
         ffx2_ff <= ffx2_in;
      end
      if (cmd.st_y) begin
         y_ff <= y_in;
      end
      if (cmd.st_yq) begin
         yq_ff <= yq_in;
         xi_ff <= xi_in;
      end
      if (cmd.st_mul) begin
         mhi1_ff <= mhi1_in;
         mhi2_ff <= mhi2_in;
         mlo1_ff <= mlo1_in;
         mlo2_ff <= mlo2_in;
      end
      if (cmd.st_psum) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (cmd.st_sub) begin
         t1_ff  <= t1_in;
         s2n_ff <= s2n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_state) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (cmd.st_upd) begin
         s1_ff <= s1_in;
         s2_ff <= s2n_ff;
      end
   end

endmodule

FILE: hw/rtl/multipass_biquad_filter.sv
// Top level of the multipass biquad filter: register file, controller and datapath.
// The block takes words of signed 32-bit samples, one per cycle, into a store of BLOCK_DEPTH
// entries until a word marked block_end arrives or the store is full. It then runs a biquad in
// transposed direct form II over the stored block as many times as the passes register says
// (zero counts as one), carrying the two state words from pass to pass and clearing them when
// the next block starts. Each sample of a pass runs through the recursive loop of the output
// adder, the rounding stage, the feedback multipliers, their sum and the two saturating state
// adders; each pass first fetches its first sample from the store. The results then leave one
// word per cycle while rsp_ready is high, once the first has been fetched, in Q32.16 with the
// last marked. No sample is taken from the end of loading until the last result is accepted.
// Registers lie at byte addresses 0x00 coef_ff0, 0x04 coef_ff1, 0x08 coef_ff2, 0x0C coef_fb1,
// 0x10 coef_fb2 and 0x14 passes; coefficients have COEF_FRAC_BITS fraction bits.
module multipass_biquad_filter import mbf_pkg::*; #(
   parameter int BLOCK_DEPTH    = BLOCK_DEPTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(BLOCK_DEPTH);

   cfg_type             cfg;
   dp_cmd_type          cmd;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic [RESULT_W-1:0] filtered;
   logic                rsp_end;

   mbf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   mbf_ctrl #(
      .BLOCK_DEPTH (BLOCK_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_block_end (req_word.block_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_end       (rsp_end),
      .passes        (cfg.passes),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr)
   );

   mbf_dp #(
      .BLOCK_DEPTH    (BLOCK_DEPTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .req_sample   (req_word.sample),
      .rsp_filtered (filtered)
   );

   assign rsp_word.filtered   = filtered;
   assign rsp_word.result_end = rsp_end;

endmodule

FILE: hw/rtl/mbf_checker.sv
// Port-level assertions for the multipass biquad filter and their binding to the top level.
`include "assert_macros.svh"

module mbf_checker import mbf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   `ASSERT_NEVER(a_no_load_while_emitting, clock, reset, req_ready && rsp_valid, "Sample accepted while results are pending")

   `ASSERT_CLK(a_block_end_stops_loading, clock, reset, req_valid && req_ready && req_word.block_end |=> !req_ready, "Loading continued after the block end word")

   `ASSERT_CLK(a_last_result_reopens, clock, reset, rsp_valid && rsp_ready && rsp_word.result_end |=> req_ready && !rsp_valid, "Block did not return to loading after its last result")

   `ASSERT_CLK(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "Result word changed while stalled")

endmodule

bind multipass_biquad_filter mbf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
